// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL of the linked-list block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define CDLL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Invariant checked at every rising edge outside reset.
`define CDLL_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

// ===== rtl/core/cdll_pkg.sv =====
// ----------------------------------------------------------------------------
// cdll_pkg
// Types and constants of the linked-list block: sizes, action and status
// codes, and the control word broadcast to the row of list cells.
// ----------------------------------------------------------------------------
`default_nettype none

package cdll_pkg;

    localparam int SLOTS      = 256;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        ACT_APPEND  = 3'd0,
        ACT_INSERT  = 3'd1,
        ACT_REM_POS = 3'd2,
        ACT_REM_VAL = 3'd3,
        ACT_SEARCH  = 3'd4,
        ACT_READ    = 3'd5,
        ACT_CLEAR   = 3'd6,
        ACT_NONE    = 3'd7
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_RANGE     = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    // Control word seen by every cell in the same cycle.
    typedef struct packed {
        logic                  ins;
        logic                  rem;
        logic                  cmp;
        logic [IDX_W-1:0]      pos;
        logic [VALUE_BITS-1:0] data;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/cursor_doubly_linked_list.sv =====
// ----------------------------------------------------------------------------
// cursor_doubly_linked_list
// Linked list of up to SLOTS values with append, insert, remove, search,
// read and clear requests, each answered by one result word.
// ----------------------------------------------------------------------------
// Usage:
//   A request word (action, position, value) is taken on in_valid/in_ready;
//   one result word (status, found_position, value_out, count) leaves on
//   out_valid/out_ready for every request.
//   The elements sit in a row of cells in list order, so insert and remove
//   shift all the cells behind the position at once. Append, insert,
//   remove at position, read and clear pass from acceptance through the
//   execute and done states into the output register. Search and remove by
//   value compare all cells at once, then step a scan counter over the
//   match flags one position per cycle up to the match position (or count
//   if absent) before the done state and the output register.
//   One request is in work at a time; in_ready is high only while idle.
//   A finished result waits in its own output register, so the block can
//   take the next request while the receiver stalls the previous result.
//   Reset empties the list at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_doubly_linked_list (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [2:0]                          action,
    input  wire logic [8:0]                          position,
    input  wire logic signed [31:0]                  value,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic      [2:0]                          status,
    output logic      [7:0]                          found_position,
    output logic signed [31:0]                       value_out,
    output logic      [8:0]                          count
);

    `include "assert_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                            state_reg, state_next;
    cdll_pkg::action_t                 act_reg, act_next;
    logic [8:0]                        pos_reg, pos_next;
    logic [cdll_pkg::VALUE_BITS-1:0]   key_reg, key_next;
    logic [cdll_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [cdll_pkg::CNT_W-1:0]        scan_reg, scan_next;
    cdll_pkg::status_t                 res_status_reg, res_status_next;
    logic [7:0]                        res_fpos_reg, res_fpos_next;
    logic [cdll_pkg::VALUE_BITS-1:0]   res_val_reg, res_val_next;
    logic                              out_valid_reg, out_valid_next;
    logic [2:0]                        out_status_reg, out_status_next;
    logic [7:0]                        out_fpos_reg, out_fpos_next;
    logic [31:0]                       out_val_reg, out_val_next;
    logic [8:0]                        out_count_reg, out_count_next;

    cdll_pkg::cell_ctrl_t                                    ctrl;
    logic [cdll_pkg::SLOTS-1:0][cdll_pkg::VALUE_BITS-1:0]    vals;
    logic [cdll_pkg::SLOTS-1:0]                              hit_flags;
    logic                                                    load_out;

    cdll_chain u_chain (
        .clk       (clk),
        .ctrl      (ctrl),
        .vals      (vals),
        .hit_flags (hit_flags)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // Request sequencer.
    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        pos_next        = pos_reg;
        key_next        = key_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        res_status_next = res_status_reg;
        res_fpos_next   = res_fpos_reg;
        res_val_next    = res_val_reg;
        ctrl            = '0;
        ctrl.data       = key_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next   = cdll_pkg::action_t'(action);
                    pos_next   = position;
                    key_next   = cdll_pkg::VALUE_BITS'(value);
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_status_next = cdll_pkg::ST_OK;
                res_fpos_next   = '0;
                res_val_next    = '0;
                state_next      = S_DONE;
                case (act_reg)
                    cdll_pkg::ACT_APPEND:
                    begin
                        if (count_reg == cdll_pkg::CNT_W'(cdll_pkg::SLOTS))
                            res_status_next = cdll_pkg::ST_FULL;
                        else
                        begin
                            ctrl.ins   = 1'b1;
                            ctrl.pos   = count_reg[cdll_pkg::IDX_W-1:0];
                            count_next = count_reg + 1'b1;
                        end
                    end
                    cdll_pkg::ACT_INSERT:
                    begin
                        if (pos_reg > count_reg)
                            res_status_next = cdll_pkg::ST_RANGE;
                        else if (count_reg == cdll_pkg::CNT_W'(cdll_pkg::SLOTS))
                            res_status_next = cdll_pkg::ST_FULL;
                        else
                        begin
                            ctrl.ins   = 1'b1;
                            ctrl.pos   = pos_reg[cdll_pkg::IDX_W-1:0];
                            count_next = count_reg + 1'b1;
                        end
                    end
                    cdll_pkg::ACT_REM_POS, cdll_pkg::ACT_READ:
                    begin
                        if (count_reg == '0)
                            res_status_next = cdll_pkg::ST_EMPTY;
                        else if (pos_reg >= count_reg)
                            res_status_next = cdll_pkg::ST_RANGE;
                        else
                        begin
                            res_val_next = vals[pos_reg[cdll_pkg::IDX_W-1:0]];
                            if (act_reg == cdll_pkg::ACT_REM_POS)
                            begin
                                ctrl.rem   = 1'b1;
                                ctrl.pos   = pos_reg[cdll_pkg::IDX_W-1:0];
                                count_next = count_reg - 1'b1;
                            end
                        end
                    end
                    cdll_pkg::ACT_REM_VAL, cdll_pkg::ACT_SEARCH:
                    begin
                        if (count_reg == '0)
                            res_status_next = cdll_pkg::ST_EMPTY;
                        else
                        begin
                            ctrl.cmp   = 1'b1;
                            scan_next  = '0;
                            state_next = S_SCAN;
                        end
                    end
                    cdll_pkg::ACT_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                        res_status_next = cdll_pkg::ST_OK;
                    end
                endcase
            end
            S_SCAN:
            begin
                // One match flag per cycle, from the head onwards.
                if (scan_reg == count_reg)
                begin
                    res_status_next = cdll_pkg::ST_NOT_FOUND;
                    state_next      = S_DONE;
                end
                else if (hit_flags[scan_reg[cdll_pkg::IDX_W-1:0]])
                begin
                    res_fpos_next = scan_reg[7:0];
                    if (act_reg == cdll_pkg::ACT_REM_VAL)
                    begin
                        res_val_next = vals[scan_reg[cdll_pkg::IDX_W-1:0]];
                        ctrl.rem     = 1'b1;
                        ctrl.pos     = scan_reg[cdll_pkg::IDX_W-1:0];
                        count_next   = count_reg - 1'b1;
                    end
                    state_next = S_DONE;
                end
                else
                    scan_next = scan_reg + 1'b1;
            end
            S_DONE:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register for the result word.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_fpos_next   = out_fpos_reg;
        out_val_next    = out_val_reg;
        out_count_next  = out_count_reg;
        if (load_out)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_fpos_next   = res_fpos_reg;
            out_val_next    = 32'(res_val_reg);
            out_count_next  = 9'(count_reg);
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request and result payload.
    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        pos_reg        <= pos_next;
        key_reg        <= key_next;
        scan_reg       <= scan_next;
        res_status_reg <= res_status_next;
        res_fpos_reg   <= res_fpos_next;
        res_val_reg    <= res_val_next;
        out_status_reg <= out_status_next;
        out_fpos_reg   <= out_fpos_next;
        out_val_reg    <= out_val_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign found_position = out_fpos_reg;
    assign value_out      = out_val_reg;
    assign count          = out_count_reg;

    `CDLL_ALWAYS(a_count_bound, count_reg <= cdll_pkg::CNT_W'(cdll_pkg::SLOTS), "count above store size")
    `CDLL_ASSERT(a_scan_bound, (state_reg == S_SCAN) |-> (scan_reg <= count_reg), "scan ran past the list")
    `CDLL_ASSERT(a_clear, (state_reg == S_EXEC && act_reg == cdll_pkg::ACT_CLEAR) |=> (count_reg == '0), "clear left elements")
    `CDLL_ASSERT(a_no_shift_scan, (state_reg == S_SCAN) |-> !ctrl.ins, "insert during scan")

endmodule

`default_nettype wire

// ===== rtl/core/cdll_cell.sv =====
// ----------------------------------------------------------------------------
// cdll_cell
// One list position: holds the element value and a registered match flag,
// and takes its left or right neighbour's value when the list opens or closes.
// ----------------------------------------------------------------------------
`default_nettype none

module cdll_cell (
    input  wire logic                           clk,
    input  wire logic [cdll_pkg::IDX_W-1:0]     idx,
    input  wire cdll_pkg::cell_ctrl_t           ctrl,
    input  wire logic [cdll_pkg::VALUE_BITS-1:0] left_val,
    input  wire logic [cdll_pkg::VALUE_BITS-1:0] right_val,
    output logic      [cdll_pkg::VALUE_BITS-1:0] val,
    output logic                                match
);

    logic [cdll_pkg::VALUE_BITS-1:0] val_reg, val_next;
    logic                            match_reg, match_next;

    // Insert opens a gap at the position; removal closes it.
    always_comb
    begin
        val_next   = val_reg;
        match_next = match_reg;
        if (ctrl.ins)
        begin
            if (idx > ctrl.pos)
                val_next = left_val;
            else if (idx == ctrl.pos)
                val_next = ctrl.data;
        end
        else if (ctrl.rem)
        begin
            if (idx >= ctrl.pos)
                val_next = right_val;
        end
        if (ctrl.cmp)
            match_next = (val_reg == ctrl.data);
    end

    // Payload only, so no reset.
    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        match_reg <= match_next;
    end

    assign val   = val_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

// ===== rtl/core/cdll_chain.sv =====
// ----------------------------------------------------------------------------
// cdll_chain
// The row of list cells in list order, each wired to its two neighbours.
// ----------------------------------------------------------------------------
`default_nettype none

module cdll_chain (
    input  wire logic                 clk,
    input  wire cdll_pkg::cell_ctrl_t ctrl,
    output logic [cdll_pkg::SLOTS-1:0][cdll_pkg::VALUE_BITS-1:0] vals,
    output logic [cdll_pkg::SLOTS-1:0]                           hit_flags
);

    genvar g;

    // Each cell sees its neighbours; the ends see zero.
    for (g = 0; g < cdll_pkg::SLOTS; g++)
    begin : g_cell
        logic [cdll_pkg::VALUE_BITS-1:0] left_v, right_v;

        if (g == 0)
        begin : g_first
            assign left_v = '0;
        end
        else
        begin : g_mid_l
            assign left_v = vals[g-1];
        end

        if (g == cdll_pkg::SLOTS - 1)
        begin : g_last
            assign right_v = '0;
        end
        else
        begin : g_mid_r
            assign right_v = vals[g+1];
        end

        cdll_cell u_cell (
            .clk       (clk),
            .idx       (cdll_pkg::IDX_W'(g)),
            .ctrl      (ctrl),
            .left_val  (left_v),
            .right_val (right_v),
            .val       (vals[g]),
            .match     (hit_flags[g])
        );
    end

endmodule

`default_nettype wire

// ===== verif/cursor_doubly_linked_list_tb.sv =====
// ----------------------------------------------------------------------------
// cursor_doubly_linked_list_tb
// Self-checking bench for the linked-list block. A queue of request words is
// built up front and fed to the block by a clocked driver. The driver keeps
// its own model of the list as an ordered queue of values and predicts each
// result word when the request is accepted. A clocked monitor compares every
// result word with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_doubly_linked_list_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 400;

    typedef enum int {PH_BUSY, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} idle_phase_t;

    typedef struct {
        cdll_pkg::action_t act;
        logic [8:0]        pos;
        logic [31:0]       val;
        idle_phase_t       phase;
        bit                hold;
        bit                drain;
    } request_t;

    typedef struct {
        cdll_pkg::status_t st;
        logic [7:0]        fpos;
        logic [31:0]       vout;
        logic [8:0]        cnt;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [2:0] action = '0;
    logic [8:0] position = '0;
    logic signed [31:0] value = '0;
    logic out_ready = 1'b0;
    logic in_ready;
    logic out_valid;
    logic [2:0] status;
    logic [7:0] found_position;
    logic signed [31:0] value_out;
    logic [8:0] count;

    request_t    pending_reqs[$];
    answer_t     expected_answers[$];
    logic [31:0] list_values[$];
    logic [31:0] value_pool[8];
    idle_phase_t cur_phase = PH_BUSY;
    int          hold_token = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          errors = 0;
    int          gen_count = 0;

    cursor_doubly_linked_list u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .position(position), .value(value),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .found_position(found_position),
        .value_out(value_out), .count(count)
    );

    always #5 clk = ~clk;

    // Work out the result word of one request and update the list copy.
    function automatic answer_t apply_request(request_t r);
        answer_t a;
        int size;
        int hit;
        a = '{cdll_pkg::ST_OK, 8'd0, 32'd0, 9'd0};
        size = list_values.size();
        hit = -1;
        case (r.act)
            cdll_pkg::ACT_APPEND:
                if (size >= cdll_pkg::SLOTS)
                    a.st = cdll_pkg::ST_FULL;
                else
                    list_values.push_back(r.val);
            cdll_pkg::ACT_INSERT:
                if (r.pos > size)
                    a.st = cdll_pkg::ST_RANGE;
                else if (size >= cdll_pkg::SLOTS)
                    a.st = cdll_pkg::ST_FULL;
                else
                    list_values.insert(r.pos, r.val);
            cdll_pkg::ACT_REM_POS, cdll_pkg::ACT_READ:
                if (size == 0)
                    a.st = cdll_pkg::ST_EMPTY;
                else if (r.pos >= size)
                    a.st = cdll_pkg::ST_RANGE;
                else
                begin
                    a.vout = list_values[r.pos];
                    if (r.act == cdll_pkg::ACT_REM_POS)
                        list_values.delete(r.pos);
                end
            cdll_pkg::ACT_REM_VAL, cdll_pkg::ACT_SEARCH:
                if (size == 0)
                    a.st = cdll_pkg::ST_EMPTY;
                else
                begin
                    for (int i = size - 1; i >= 0; i--)
                        if (list_values[i] == r.val)
                            hit = i;
                    if (hit < 0)
                        a.st = cdll_pkg::ST_NOT_FOUND;
                    else
                    begin
                        a.fpos = hit[7:0];
                        if (r.act == cdll_pkg::ACT_REM_VAL)
                        begin
                            a.vout = list_values[hit];
                            list_values.delete(hit);
                        end
                    end
                end
            cdll_pkg::ACT_CLEAR:
                list_values.delete();
            default:
                ;
        endcase
        a.cnt = 9'(list_values.size());
        return a;
    endfunction

    // Queue one request word, keeping a rough element count for positions.
    task automatic add_req(cdll_pkg::action_t act, int pos, logic [31:0] val,
                           idle_phase_t ph, bit hold = 0, bit drain = 0);
        request_t r;
        r = '{act, pos[8:0], val, ph, hold, drain};
        pending_reqs.push_back(r);
        case (act)
            cdll_pkg::ACT_APPEND: if (gen_count < cdll_pkg::SLOTS) gen_count++;
            cdll_pkg::ACT_INSERT:
                if (pos <= gen_count && gen_count < cdll_pkg::SLOTS) gen_count++;
            cdll_pkg::ACT_REM_POS: if (pos < gen_count) gen_count--;
            cdll_pkg::ACT_REM_VAL: if (gen_count > 0) gen_count--;
            cdll_pkg::ACT_CLEAR: gen_count = 0;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 9) < 8)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // Mostly sensible requests on a list of moderate length.
    task automatic add_random_block(idle_phase_t ph, int n);
        int sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 25 || gen_count < 2)
                add_req(cdll_pkg::ACT_APPEND, $urandom_range(0, 511), pick_value(), ph,
                        0, i == 0);
            else if (sel < 40)
                add_req(cdll_pkg::ACT_INSERT, $urandom_range(0, gen_count + 1),
                        pick_value(), ph);
            else if (sel < 52)
                add_req(cdll_pkg::ACT_REM_POS, $urandom_range(0, gen_count),
                        pick_value(), ph);
            else if (sel < 64)
                add_req(cdll_pkg::ACT_REM_VAL, $urandom_range(0, 511), pick_value(), ph);
            else if (sel < 78)
                add_req(cdll_pkg::ACT_SEARCH, $urandom_range(0, 511), pick_value(), ph);
            else if (sel < 92)
                add_req(cdll_pkg::ACT_READ, $urandom_range(0, gen_count), pick_value(), ph);
            else if (sel < 95)
                add_req(cdll_pkg::ACT_NONE, $urandom_range(0, 511), $urandom, ph);
            else if (sel < 97 || gen_count > 60)
                add_req(cdll_pkg::ACT_CLEAR, $urandom_range(0, 511), $urandom, ph);
            else
                add_req(cdll_pkg::action_t'($urandom_range(0, 7)), $urandom_range(0, 511),
                        $urandom, ph);
        end
    endtask

    // Driver: predicts each accepted word and offers the next one.
    always @(posedge clk or negedge rst_n)
    begin
        request_t r;
        int idle_pct;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_answers.push_back(apply_request(pending_reqs.pop_front()));
            if (!(in_valid && !in_ready))
            begin
                idle_pct = (cur_phase == PH_SEND_IDLE) ? 85 : (cur_phase == PH_BOTH) ? 12 : 0;
                if (pending_reqs.size() > 0 && !(in_valid && in_ready))
                    cur_phase = pending_reqs[0].phase;
                if (pending_reqs.size() > 0 && !(in_valid && in_ready)
                    && !(pending_reqs[0].drain && expected_answers.size() != 0)
                    && $urandom_range(0, 99) >= idle_pct)
                begin
                    r = pending_reqs[0];
                    if (r.hold)
                        hold_token <= hold_token + 1;
                    action   <= r.act;
                    position <= r.pos;
                    value    <= r.val;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks result words and drives the receiver stalls.
    always @(posedge clk or negedge rst_n)
    begin
        answer_t e;
        int stall_pct;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_answers.size() == 0)
                begin
                    $display("%0t: unexpected result word status=%0d", $time, status);
                    errors++;
                end
                else
                begin
                    e = expected_answers.pop_front();
                    if (status !== e.st)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time, e.st, status);
                        errors++;
                    end
                    if (found_position !== e.fpos)
                    begin
                        $display("%0t: found_position expected %0d actual %0d",
                                 $time, e.fpos, found_position);
                        errors++;
                    end
                    if (value_out !== e.vout)
                    begin
                        $display("%0t: value_out expected %h actual %h", $time, e.vout, value_out);
                        errors++;
                    end
                    if (count !== e.cnt)
                    begin
                        $display("%0t: count expected %0d actual %0d", $time, e.cnt, count);
                        errors++;
                    end
                end
            end
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            stall_pct = (cur_phase == PH_RECV_STALL) ? 85 : (cur_phase == PH_BOTH) ? 12 : 0;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Stimulus and end of run.
    initial
    begin
        value_pool = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0,
                       32'd1, 32'd42, 32'h5A5A_A5A5, 32'h1234_5678};

        // Directed: extremes, every action and the special cases.
        add_req(cdll_pkg::ACT_APPEND, 0, 32'h8000_0000, PH_BUSY);
        add_req(cdll_pkg::ACT_APPEND, 511, 32'h7FFF_FFFF, PH_BUSY);
        add_req(cdll_pkg::ACT_INSERT, 0, 32'hFFFF_FFFF, PH_BUSY);
        add_req(cdll_pkg::ACT_INSERT, 3, 32'd0, PH_BUSY);
        add_req(cdll_pkg::ACT_INSERT, 1, 32'd42, PH_BUSY);
        add_req(cdll_pkg::ACT_INSERT, 511, 32'd5, PH_BUSY);
        add_req(cdll_pkg::ACT_READ, 0, 32'd0, PH_BUSY);
        add_req(cdll_pkg::ACT_READ, 4, 32'd0, PH_BUSY);
        add_req(cdll_pkg::ACT_READ, 256, 32'd0, PH_BUSY);
        add_req(cdll_pkg::ACT_SEARCH, 0, 32'd0, PH_BUSY);
        add_req(cdll_pkg::ACT_SEARCH, 0, 32'd77, PH_BUSY);
        add_req(cdll_pkg::ACT_REM_VAL, 0, 32'h7FFF_FFFF, PH_BUSY);
        add_req(cdll_pkg::ACT_REM_VAL, 0, 32'd77, PH_BUSY);
        add_req(cdll_pkg::ACT_REM_POS, 0, 32'd0, PH_BUSY);
        add_req(cdll_pkg::ACT_REM_POS, 9, 32'd0, PH_BUSY);
        add_req(cdll_pkg::ACT_NONE, 511, 32'hFFFF_FFFF, PH_BUSY);
        add_req(cdll_pkg::ACT_CLEAR, 0, 32'd0, PH_BUSY);
        add_req(cdll_pkg::ACT_READ, 0, 32'd0, PH_BUSY);
        add_req(cdll_pkg::ACT_REM_POS, 0, 32'd0, PH_BUSY);
        add_req(cdll_pkg::ACT_REM_VAL, 0, 32'd0, PH_BUSY);
        add_req(cdll_pkg::ACT_SEARCH, 0, 32'd0, PH_BUSY);
        add_req(cdll_pkg::ACT_APPEND, 0, 32'd9, PH_BUSY);
        add_req(cdll_pkg::ACT_REM_POS, 0, 32'd0, PH_BUSY);
        add_req(cdll_pkg::ACT_APPEND, 0, 32'd3, PH_BUSY);

        // Fill the store to the brim, with a long receiver hold on the way.
        for (int i = 0; i < cdll_pkg::SLOTS + 2; i++)
            add_req(cdll_pkg::ACT_APPEND, 0, (i == 100) ? 32'd42 : $urandom, PH_BUSY,
                    i == 10);
        add_req(cdll_pkg::ACT_INSERT, 0, 32'd1, PH_BUSY);
        add_req(cdll_pkg::ACT_INSERT, 257, 32'd1, PH_BUSY);
        add_req(cdll_pkg::ACT_INSERT, 256, 32'd1, PH_BUSY);
        add_req(cdll_pkg::ACT_READ, 255, 32'd0, PH_BUSY);
        add_req(cdll_pkg::ACT_READ, 256, 32'd0, PH_BUSY);
        add_req(cdll_pkg::ACT_SEARCH, 0, 32'd42, PH_BUSY);
        add_req(cdll_pkg::ACT_SEARCH, 0, 32'hDEAD_0001, PH_BUSY);
        add_req(cdll_pkg::ACT_REM_POS, 255, 32'd0, PH_BUSY);
        add_req(cdll_pkg::ACT_INSERT, 255, 32'd7, PH_BUSY);
        add_req(cdll_pkg::ACT_CLEAR, 0, 32'd0, PH_BUSY, 0, 1);

        // Random traffic under each idling pattern.
        add_random_block(PH_BUSY, 130);
        add_random_block(PH_SEND_IDLE, 130);
        add_random_block(PH_RECV_STALL, 130);
        add_random_block(PH_BOTH, 130);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_reqs.size() == 0 && !in_valid && expected_answers.size() == 0);
        repeat (300) @(posedge clk);
        if (errors == 0 && expected_answers.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/cdll_pkg.sv
rtl/core/cdll_cell.sv
rtl/core/cdll_chain.sv
rtl/core/cursor_doubly_linked_list.sv
verif/cursor_doubly_linked_list_tb.sv
